/* sv/differential_drive_odometry_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the odometry core
// Concurrent checks, clocked on clk; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// check outside reset
`define ODO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define ODO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ODO_ASSERT(lbl, prop, msg)
`define ODO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/odo_pkg.sv */
// ---------------------------------------------------------------------------
// Odometry package
// Beat types, fixed-point widths and constants shared by the odometry core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package odo_pkg;

  localparam int SEP_W      = 18;
  localparam int X_W        = 57;   // CORDIC vector width
  localparam int Z_W        = 34;   // CORDIC angle width
  localparam int COUT_W     = 27;   // rounded CORDIC result width
  localparam int DIV_N_W    = 64;   // dividend width
  localparam int DIV_D_W    = 32;   // divisor width
  localparam int MUL_A_W    = 41;
  localparam int MUL_B_W    = 30;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SEP_W-1:0]   SEP_RESET    = 18'd11338;
  localparam logic [MUL_B_W-1:0] TURN_TO_BAM  = 30'd683565276;
  localparam logic [MUL_B_W-1:0] CORDIC_GAIN  = 30'd652032874;
  localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 30'd1000000;

  // arctan(2^-i) as binary angle
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [23:0] left_distance;
    logic signed [23:0] right_distance;
    logic [31:0]        elapsed_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading_angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic               zero_time_flag;
  } out_beat_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic        d_neg;
    logic [23:0] d_mag;
    logic        diff_neg;
    logic [24:0] diff_mag;
    logic [31:0] elapsed;
    logic        zero_time;
  } tick_t;

  // divider and CORDIC status
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* sv/odo_front.sv */
// ---------------------------------------------------------------------------
// Odometry front end
// Takes input beats and splits them into mean distance, wheel difference and
// time class as sign and magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module odo_front (
  input  odo_pkg::in_beat_t in_data,
  output odo_pkg::tick_t    tick
);
  import odo_pkg::*;

  logic signed [24:0] sum;
  logic signed [24:0] diff;
  logic signed [23:0] d;

  // mean distance floors, difference is exact
  always_comb begin
    sum  = {in_data.left_distance[23], in_data.left_distance}
         + {in_data.right_distance[23], in_data.right_distance};
    diff = {in_data.right_distance[23], in_data.right_distance}
         - {in_data.left_distance[23], in_data.left_distance};
    d    = sum[24:1];
    tick.d_neg     = d[23];
    tick.d_mag     = d[23] ? 24'(-d) : 24'(d);
    tick.diff_neg  = diff[24];
    tick.diff_mag  = diff[24] ? 25'(-diff) : 25'(diff);
    tick.elapsed   = in_data.elapsed_time;
    tick.zero_time = (in_data.elapsed_time == 32'd0);
  end

endmodule

/* sv/odo_fifo.sv */
// ---------------------------------------------------------------------------
// Odometry tick queue
// Short register queue between front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_odometry_core_macros.svh"
module odo_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  odo_pkg::tick_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output odo_pkg::tick_t rd_data
);
  import odo_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  `ODO_ASSERT(a_fifo_bound, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

/* sv/odo_div.sv */
// ---------------------------------------------------------------------------
// Odometry divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module odo_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [odo_pkg::DIV_N_W-1:0]  dividend,
  input  logic [odo_pkg::DIV_D_W-1:0]  divisor,
  output odo_pkg::unit_stat_t          stat,
  output logic [odo_pkg::DIV_N_W-1:0]  quotient
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W+1:0] trial;
  logic               ge;

  // one trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_N_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = !trial[DIV_D_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses once after the last step
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_N_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? trial[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* sv/odo_cordic.sv */
// ---------------------------------------------------------------------------
// Odometry CORDIC
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// half-turn folding and rounded outputs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module odo_cordic #(
  parameter int STAGES = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [odo_pkg::X_W-1:0]     x_in,
  input  logic [31:0]                        angle,
  output odo_pkg::unit_stat_t                stat,
  output logic signed [odo_pkg::COUT_W-1:0]  cx,
  output logic signed [odo_pkg::COUT_W-1:0]  cy
);
  import odo_pkg::*;

  localparam int N = (STAGES > 32) ? 32 : STAGES;
  localparam logic signed [Z_W-1:0] QUARTER = Z_W'(64'sd1073741824);
  localparam logic signed [Z_W-1:0] HALF    = Z_W'(64'sd2147483648);
  localparam logic signed [X_W-1:0] RND     = X_W'(64'sd536870912);

  logic signed [X_W-1:0] x_r, y_r, xs, ys, xr, yr;
  logic signed [Z_W-1:0] z_r, z0, at;
  logic [4:0]            iter_r;
  logic                  busy_r;
  logic                  done_r;

  always_comb begin
    z0 = {{(Z_W-32){angle[31]}}, angle};
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    at = {{(Z_W-32){1'b0}}, ATAN_BAM[iter_r]};
    xr = x_r + RND;
    yr = y_r + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      // done pulses once after the last micro-rotation
      done_r <= !start && busy_r && (iter_r == 5'(N - 1));
      if (start) begin
        // fold angles past a quarter turn
        y_r    <= '0;
        iter_r <= '0;
        busy_r <= 1'b1;
        if (z0 > QUARTER) begin
          z_r <= z0 - HALF;
          x_r <= -x_in;
        end else if (z0 < -QUARTER) begin
          z_r <= z0 + HALF;
          x_r <= -x_in;
        end else begin
          z_r <= z0;
          x_r <= x_in;
        end
      end else if (busy_r) begin
        if (!z_r[Z_W-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        iter_r <= iter_r + 1'b1;
        if (iter_r == 5'(N - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign cx = xr[X_W-1:30];
  assign cy = yr[X_W-1:30];

endmodule

/* sv/odo_back.sv */
// ---------------------------------------------------------------------------
// Odometry back end
// Sequencer over a shared multiplier, divider and CORDIC; holds the pose and
// the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_odometry_core_macros.svh"
module odo_back #(
  parameter int CORDIC_STAGES = 20,
  parameter int POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [odo_pkg::SEP_W-1:0]     sep,
  input  logic                          q_empty,
  input  odo_pkg::tick_t                q_data,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output odo_pkg::out_beat_t            out_data
);
  import odo_pkg::*;

  localparam int PE_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_BAM, S_DIV_BAM, S_DIV_Q16, S_MUL_GAIN,
    S_ROT_POS, S_ROT_VEL, S_VEL_MUL, S_VEL_DIV, S_OUT
  } state_t;

  state_t                       state_r;
  tick_t                        tk_r;
  logic                         launched_r;
  logic [31:0]                  bam_r;
  logic [MUL_A_W-1:0]           q16_mag_r;
  logic signed [X_W-1:0]        x0_r;
  logic signed [COUT_W-1:0]     vx_r, vy_r;
  logic [1:0]                   vi_r;
  logic signed [31:0]           vel_r [3];
  logic [POSITION_BITS-1:0]     px_r, py_r;
  logic [31:0]                  heading_r;
  logic                         out_valid_r;
  out_beat_t                    out_r;
  logic [MUL_A_W+MUL_B_W-1:0]   mul_p_r;

  logic [MUL_A_W-1:0]           mul_a;
  logic [MUL_B_W-1:0]           mul_b;
  logic [DIV_N_W-1:0]           div_n;
  logic [DIV_D_W-1:0]           div_d;
  logic                         div_start, cord_start;
  unit_stat_t                   div_stat, cord_stat;
  logic [DIV_N_W-1:0]           quo;
  logic signed [X_W-1:0]        x0_fresh, cord_x;
  logic [31:0]                  cord_ang;
  logic signed [COUT_W-1:0]     cx, cy;
  logic [DIV_D_W-1:0]           sep_eff;
  logic                         v_neg;
  logic [COUT_W-1:0]            v_small;
  logic [MUL_A_W-1:0]           v_mag;
  logic signed [31:0]           v_sat;
  logic [63:0]                  dx_ext, dy_ext;
  logic [PE_W-1:0]              px_ext, py_ext;
  logic                         can_load;

  assign sep_eff  = (sep == '0) ? DIV_D_W'(1) : DIV_D_W'(sep);
  assign x0_fresh = tk_r.d_neg ? -X_W'(mul_p_r) : X_W'(mul_p_r);
  assign can_load = !out_valid_r || out_pop;

  // magnitude of the current velocity term
  always_comb begin
    case (vi_r)
      2'd0:    v_small = vx_r[COUT_W-1] ? COUT_W'(-vx_r) : COUT_W'(vx_r);
      2'd1:    v_small = vy_r[COUT_W-1] ? COUT_W'(-vy_r) : COUT_W'(vy_r);
      default: v_small = '0;
    endcase
    case (vi_r)
      2'd0:    v_neg = vx_r[COUT_W-1];
      2'd1:    v_neg = vy_r[COUT_W-1];
      default: v_neg = tk_r.diff_neg;
    endcase
    v_mag = (vi_r == 2'd2) ? q16_mag_r : MUL_A_W'(v_small);
  end

  // truncated quotient, saturated to 32 bits
  always_comb begin
    if (!v_neg) begin
      v_sat = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end else begin
      v_sat = (quo >= 64'h8000_0000) ? 32'sh8000_0000 : $signed(-quo[31:0]);
    end
  end

  // shared multiplier operands
  always_comb begin
    case (state_r)
      S_MUL_BAM:  begin mul_a = MUL_A_W'(tk_r.diff_mag); mul_b = TURN_TO_BAM;  end
      S_MUL_GAIN: begin mul_a = MUL_A_W'(tk_r.d_mag);    mul_b = CORDIC_GAIN;  end
      default:    begin mul_a = v_mag;                   mul_b = USEC_PER_SEC; end
    endcase
  end

  // divider and CORDIC operands
  always_comb begin
    div_n      = (state_r == S_DIV_Q16) ? DIV_N_W'({tk_r.diff_mag, 16'h0000})
                                        : mul_p_r[DIV_N_W-1:0];
    div_d      = (state_r == S_VEL_DIV) ? tk_r.elapsed : sep_eff;
    div_start  = !launched_r && (state_r == S_DIV_BAM || state_r == S_DIV_Q16 ||
                                 state_r == S_VEL_DIV);
    cord_start = !launched_r && (state_r == S_ROT_POS || state_r == S_ROT_VEL);
    cord_x     = (state_r == S_ROT_POS) ? x0_fresh : x0_r;
    cord_ang   = (state_r == S_ROT_POS) ? heading_r : bam_r;
    dx_ext     = {{(64-COUT_W){cx[COUT_W-1]}}, cx};
    dy_ext     = {{(64-COUT_W){cy[COUT_W-1]}}, cy};
    px_ext     = PE_W'(px_r);
    py_ext     = PE_W'(py_r);
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  odo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .stat     (div_stat),
    .quotient (quo)
  );

  odo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (cord_x),
    .angle (cord_ang),
    .stat  (cord_stat),
    .cx    (cx),
    .cy    (cy)
  );

  // product register, free running
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // sequencer, pose and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      heading_r   <= '0;
      vi_r        <= '0;
    end else begin
      // S_OUT owns the result flag while it is in that state
      if (out_pop && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (div_start || cord_start) begin
        launched_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            tk_r    <= q_data;
            state_r <= S_MUL_BAM;
          end
        end
        S_MUL_BAM: state_r <= S_DIV_BAM;
        S_DIV_BAM: begin
          if (div_stat.done) begin
            bam_r      <= tk_r.diff_neg ? -quo[31:0] : quo[31:0];
            launched_r <= 1'b0;
            state_r    <= S_DIV_Q16;
          end
        end
        S_DIV_Q16: begin
          if (div_stat.done) begin
            q16_mag_r  <= quo[MUL_A_W-1:0];
            launched_r <= 1'b0;
            state_r    <= S_MUL_GAIN;
          end
        end
        S_MUL_GAIN: state_r <= S_ROT_POS;
        S_ROT_POS: begin
          if (cord_start) begin
            x0_r <= x0_fresh;
          end
          if (cord_stat.done) begin
            px_r       <= px_r + dx_ext[POSITION_BITS-1:0];
            py_r       <= py_r + dy_ext[POSITION_BITS-1:0];
            heading_r  <= heading_r + bam_r;
            launched_r <= 1'b0;
            vi_r       <= '0;
            if (tk_r.zero_time) begin
              vel_r[0] <= '0;
              vel_r[1] <= '0;
              vel_r[2] <= '0;
              state_r  <= S_OUT;
            end else begin
              state_r  <= S_ROT_VEL;
            end
          end
        end
        S_ROT_VEL: begin
          if (cord_stat.done) begin
            vx_r       <= cx;
            vy_r       <= cy;
            launched_r <= 1'b0;
            state_r    <= S_VEL_MUL;
          end
        end
        S_VEL_MUL: state_r <= S_VEL_DIV;
        S_VEL_DIV: begin
          if (div_stat.done) begin
            vel_r[vi_r] <= v_sat;
            launched_r  <= 1'b0;
            if (vi_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              vi_r    <= vi_r + 1'b1;
              state_r <= S_VEL_MUL;
            end
          end
        end
        S_OUT: begin
          if (can_load) begin
            out_r.pos_x          <= $signed(px_ext[31:0]);
            out_r.pos_y          <= $signed(py_ext[31:0]);
            out_r.heading_angle  <= heading_r;
            out_r.vel_x          <= vel_r[0];
            out_r.vel_y          <= vel_r[1];
            out_r.yaw_rate       <= vel_r[2];
            out_r.zero_time_flag <= tk_r.zero_time;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  `ODO_ASSERT(a_idle_units, (state_r == S_IDLE) |-> !div_stat.busy && !cord_stat.busy, "unit busy while idle")
  `ODO_ASSERT(a_one_unit, !(div_stat.busy && cord_stat.busy), "divider and CORDIC both busy")
  `ODO_ASSERT(a_result_held, out_valid_r && !out_pop |=> out_valid_r && $stable(out_r), "result lost")
  `ODO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty, "result after reset")

endmodule

/* sv/differential_drive_odometry_core.sv */
// ---------------------------------------------------------------------------
// Differential-drive wheel odometry core
// Integrates wheel distances into a pose and reports per-tick velocities.
// ---------------------------------------------------------------------------
// One tick is taken per push beat and gives one result beat. The time from
// push to result is set by the shared radix-2 divider (64 steps per
// division, five divisions per tick) and by the iterative CORDIC, one
// micro-rotation per cycle. A tick whose elapsed_time is zero skips the
// velocity rotation and three of the divisions. A two-entry tick
// queue and the result register let the input side keep pushing while a
// result waits to be popped. wheel_separation is written through cfg_* and
// must only change while the core is idle; zero acts as one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module differential_drive_odometry_core #(
  parameter int CORDIC_STAGES = 20,
  parameter int POSITION_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  odo_pkg::in_beat_t          in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output odo_pkg::out_beat_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [odo_pkg::SEP_W-1:0]  cfg_data
);
  import odo_pkg::*;

  logic [SEP_W-1:0] sep_r;
  tick_t            tick, q_data;
  logic             q_empty, q_pop;

  // wheel separation register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sep_r <= cfg_data;
    end
  end

  odo_front u_front (
    .in_data (in_data),
    .tick    (tick)
  );

  odo_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (tick),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  odo_back #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sep       (sep_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
